// File: rtl/core/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types for the counting semaphore table: command and status codes,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package csem_pkg;

   typedef enum logic [1:0] {
      CMD_OPEN  = 2'd0,
      CMD_UP    = 2'd1,
      CMD_DOWN  = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_REJECT  = 3'd1,
      STATUS_ALREADY = 3'd2,
      STATUS_REACHED = 3'd3,
      STATUS_BLOCK   = 3'd4
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/core/counting_semaphore_table_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Table of counting semaphores answering open, up, down and close
// transactions with a status and the count after the command.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  command, sem_id, initial_count
//  rsp      out        rsp_valid/rsp_ready  status, count_after
//
//  Each transaction has a registered table read, then the update and
//  write-back into the result register.
//  A new transaction is taken while the previous result waits in rsp.
//  A stalled rsp holds the update until the result register frees.
//  Synchronous reset marks every semaphore closed with count zero at once.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core
   import csem_pkg::*;
#(
   parameter int SEM_COUNT   = 255,
   parameter int COUNT_WIDTH = 15
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_sem_id,
   input  logic signed [15:0]     req_initial_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [COUNT_WIDTH-1:0] rsp_count_after
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csem_dp #(
      .SEM_COUNT   (SEM_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_command),
      .req_sem_id        (req_sem_id),
      .req_initial_count (req_initial_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_count_after   (rsp_count_after)
   );

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a transaction in flight");

   a_block_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BLOCK) |-> (rsp_count_after == '0))
      else $error("would-block result with nonzero count");

   a_reached_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REACHED) |-> (rsp_count_after != '0))
      else $error("reached-initial result with zero count");
`endif

endmodule

// File: rtl/core/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Controller: takes one transaction at a time, then runs the table update
// once the result register can take the answer.
// ----------------------------------------------------------------------------
module csem_ctrl
   import csem_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   always_comb begin
      cmd.capture = req_valid && ready_ff;
      cmd.execute = (state_ff == S_EXEC) && status.out_free;
      state_in    = state_ff;
      ready_in    = ready_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
               ready_in = 1'b0;
            end
         end
         S_EXEC: begin
            if (status.out_free) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: rtl/core/csem_dp.sv
// ----------------------------------------------------------------------------
// csem_dp
// Datapath: request registers, closed flags, count and initial-count
// memories, the update logic and the result register.
// ----------------------------------------------------------------------------
module csem_dp
   import csem_pkg::*;
#(
   parameter int SEM_COUNT   = 255,
   parameter int COUNT_WIDTH = 15
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_sem_id,
   input  logic signed [15:0]     req_initial_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [COUNT_WIDTH-1:0] rsp_count_after
);

   localparam int IdxW  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
   localparam int WideW = (COUNT_WIDTH > 15) ? COUNT_WIDTH : 15;

   logic [1:0]             cmd_ff;
   logic [7:0]             id_ff;
   logic [15:0]            init_ff;
   logic [SEM_COUNT-1:0]   closed_ff;
   logic [COUNT_WIDTH-1:0] count_mem [SEM_COUNT];
   logic [COUNT_WIDTH-1:0] init_mem  [SEM_COUNT];
   logic [COUNT_WIDTH-1:0] count_rd_ff;
   logic [COUNT_WIDTH-1:0] init_rd_ff;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   logic                   id_ok;
   logic [IdxW-1:0]        idx;
   logic                   closed;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH-1:0] cnt_max;
   logic [WideW-1:0]       raw_w;
   logic [COUNT_WIDTH-1:0] sat;
   logic [COUNT_WIDTH-1:0] cnt_up;
   status_type             status_in;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   wr_count;
   logic                   wr_init;
   logic                   set_open;
   logic                   set_closed;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         id_ff   <= req_sem_id;
         init_ff <= req_initial_count;
         if (9'(req_sem_id) < 9'(SEM_COUNT)) begin
            count_rd_ff <= count_mem[req_sem_id[IdxW-1:0]];
            init_rd_ff  <= init_mem[req_sem_id[IdxW-1:0]];
         end
      end
   end

   always_comb begin
      id_ok   = 9'(id_ff) < 9'(SEM_COUNT);
      idx     = id_ff[IdxW-1:0];
      closed  = 1'b1;
      if (id_ok) begin
         closed = closed_ff[idx];
      end
      cnt     = closed ? '0 : count_rd_ff;
      cnt_max = '1;
      raw_w   = WideW'(init_ff[14:0]);
      sat     = (raw_w > WideW'(cnt_max)) ? cnt_max : COUNT_WIDTH'(raw_w);
      cnt_up  = (cnt == cnt_max) ? cnt : cnt + 1'b1;

      status_in  = STATUS_REJECT;
      count_in   = '0;
      wr_count   = 1'b0;
      wr_init    = 1'b0;
      set_open   = 1'b0;
      set_closed = 1'b0;
      if (id_ok) begin
         case (cmd_type'(cmd_ff))
            CMD_OPEN: begin
               if (init_ff[15]) begin
                  status_in = STATUS_REJECT;
               end else if (!closed) begin
                  status_in = STATUS_ALREADY;
                  count_in  = cnt;
               end else begin
                  status_in = STATUS_OK;
                  count_in  = sat;
                  wr_count  = 1'b1;
                  wr_init   = 1'b1;
                  set_open  = 1'b1;
               end
            end
            CMD_UP: begin
               count_in = cnt;
               if (!closed) begin
                  count_in  = cnt_up;
                  wr_count  = 1'b1;
                  status_in = (cnt_up >= init_rd_ff) ? STATUS_REACHED : STATUS_OK;
               end
            end
            CMD_DOWN: begin
               count_in = cnt;
               if (closed) begin
                  status_in = STATUS_REJECT;
               end else if (cnt == '0) begin
                  status_in = STATUS_BLOCK;
               end else begin
                  status_in = STATUS_OK;
                  count_in  = cnt - 1'b1;
                  wr_count  = 1'b1;
               end
            end
            CMD_CLOSE: begin
               status_in  = STATUS_OK;
               set_closed = !closed;
            end
            default: begin
               status_in = STATUS_REJECT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_count) begin
         count_mem[idx] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_init) begin
         init_mem[idx] <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= '1;
      end else if (cmd.execute && (set_open || set_closed)) begin
         closed_ff[idx] <= set_closed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;

endmodule
